FILE: sv/round_robin_quantum_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RRQS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RRQS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rrqs_pkg.sv
// Shared types and constants of the round-robin quantum scheduler.
`timescale 1ns / 1ps
package rrqs_pkg;

	localparam int TID_W          = 6;
	localparam int QV_W           = 16;
	localparam int KIND_W         = 2;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 24;
	localparam int TASK_COUNT_DEF = 64;
	localparam int IDLE_ID_DEF    = 0;

	localparam logic [TID_W-1:0] RESET_RUN_ID  = 6'd1;
	localparam logic [QV_W-1:0]  RESET_QUANTUM = 16'd10;

	typedef enum logic [KIND_W-1:0] {
		K_TICK     = 2'd0,
		K_READY    = 2'd1,
		K_DISPATCH = 2'd2,
		K_SETQ     = 2'd3
	} kind_t;

	// Command broadcast to every queue cell for one cycle.
	typedef struct packed {
		logic             rm_en;  // unlink key if present
		logic             app_en; // append key at the tail
		logic             pop;    // drop the head
		logic [TID_W-1:0] key;
	} qctl_t;

endpackage

FILE: sv/rrqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rrqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/rrqs_cell.sv
// One slot of the ready queue: holds a task number and moves it toward the head.
`timescale 1ns / 1ps
module rrqs_cell #(
	parameter int POS_W = 6,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rrqs_pkg::qctl_t            ctl,
	input  logic [POS_W-1:0]           app_pos,
	input  logic                       shift_in,
	input  logic                       nb_vld,
	input  logic [rrqs_pkg::TID_W-1:0] nb_id,
	output logic                       match,
	output logic                       vld,
	output logic [rrqs_pkg::TID_W-1:0] id
);

	logic                       vld_q;
	logic [rrqs_pkg::TID_W-1:0] id_q;
	logic                       app_here;

	// A pop looks like a match in the head slot.
	assign match    = (ctl.rm_en && vld_q && (id_q == ctl.key)) || ((IDX == 0) && ctl.pop);
	assign app_here = ctl.app_en && (app_pos == POS_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (app_here) begin
			vld_q <= 1'b1;
		end else if (shift_in) begin
			vld_q <= nb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (app_here) begin
			id_q <= ctl.key;
		end else if (shift_in) begin
			id_q <= nb_id;
		end
	end

	assign vld = vld_q;
	assign id  = id_q;

endmodule

FILE: sv/rrqs_queue.sv
// Ready queue as a row of cells, compacted toward the head by a prefix-OR of matches.
`timescale 1ns / 1ps
module rrqs_queue #(
	parameter int TASK_COUNT = rrqs_pkg::TASK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrqs_pkg::qctl_t               ctl,
	input  logic [$clog2(TASK_COUNT)-1:0] app_pos,
	output logic                          head_vld,
	output logic [rrqs_pkg::TID_W-1:0]    head_id,
	output logic                          found
);

	localparam int POS_W = $clog2(TASK_COUNT);
	localparam int LVL   = $clog2(TASK_COUNT);

	logic [TASK_COUNT-1:0]             match;
	logic [TASK_COUNT-1:0]             vld;
	logic [rrqs_pkg::TID_W-1:0]        id [TASK_COUNT];
	logic [LVL:0][TASK_COUNT-1:0]      pre;

	assign pre[0] = match;

	// Log-depth prefix OR: a cell shifts when a match sits at or before it.
	for (genvar l = 0; l < LVL; l++) begin : g_lvl
		for (genvar i = 0; i < TASK_COUNT; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
			end else begin : g_pass
				assign pre[l+1][i] = pre[l][i];
			end
		end
	end

	for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
		logic                       nb_vld;
		logic [rrqs_pkg::TID_W-1:0] nb_id;

		if (i == TASK_COUNT - 1) begin : g_last
			assign nb_vld = 1'b0;
			assign nb_id  = '0;
		end else begin : g_mid
			assign nb_vld = vld[i+1];
			assign nb_id  = id[i+1];
		end

		rrqs_cell #(
			.POS_W (POS_W),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.app_pos  (app_pos),
			.shift_in (pre[LVL][i]),
			.nb_vld   (nb_vld),
			.nb_id    (nb_id),
			.match    (match[i]),
			.vld      (vld[i]),
			.id       (id[i])
		);
	end

	assign head_vld = vld[0];
	assign head_id  = id[0];
	assign found    = pre[LVL][TASK_COUNT-1];

endmodule

FILE: sv/round_robin_quantum_scheduler_core.sv
// Top level of the round-robin scheduler with per-task time quantum.
`timescale 1ns / 1ps
`include "round_robin_quantum_scheduler_core_defines.svh"
//
// Channel   Dir  Group            Content (low bit first)
// -------   ---  ---------------  ------------------------------------------------
// s_axis    in   tvalid/tready    tuser: kind; tdata: task_id, quantum_value
// m_axis    out  tvalid/tready    tdata: running_task, quantum_left, switched,
//                                        queue_empty
// cfg       in   wr_en/wr_data    default_quantum, also reloads the running quantum
//
// One item is in flight at a time. After the accepting edge, decode (S_EXEC) leads straight
// to the result step (S_DONE) for set-quantum, a plain tick or a make-ready of an invalid
// task; a make-ready adds unlink/append (S_RA); a dispatch adds the pop (S_POP, not on an
// empty queue) and the quantum load (S_LOAD); a tick that expires the quantum and requeues
// adds all three. Each queue step and the registered quantum read has its own state.
// Reset is asynchronous and clears the queue at once; no clearing pass is needed.
// A stalled result beat holds the block in its last step; no further beat is accepted.
module round_robin_quantum_scheduler_core #(
	parameter int TASK_COUNT = rrqs_pkg::TASK_COUNT_DEF,
	parameter int IDLE_ID    = rrqs_pkg::IDLE_ID_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [rrqs_pkg::QV_W-1:0]      cfg_wr_data,   // default_quantum
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rrqs_pkg::S_TDATA_W-1:0] s_axis_tdata,  // task_id, quantum_value, 2'b0
	input  logic [rrqs_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rrqs_pkg::M_TDATA_W-1:0] m_axis_tdata   // running_task, quantum_left,
	                                                      // switched, queue_empty
);

	localparam int TID_W  = rrqs_pkg::TID_W;
	localparam int QV_W   = rrqs_pkg::QV_W;
	localparam int ADDR_W = $clog2(TASK_COUNT);
	localparam int CNT_W  = $clog2(TASK_COUNT + 1);
	localparam int EXT_W  = TID_W + ADDR_W;

	localparam logic [TID_W-1:0]  IDLE_TID  = TID_W'(IDLE_ID);
	localparam logic [ADDR_W-1:0] IDLE_ADDR = ADDR_W'(IDLE_ID);

	// Sequencer steps of one item.
	typedef enum logic [2:0] {
		S_IDLE,  // wait for an input beat
		S_EXEC,  // decode, count the tick, update quantum table
		S_RA,    // unlink key from the queue and append it at the tail
		S_POP,   // take the head as the running task
		S_LOAD,  // pick the new quantum from the memory read
		S_DONE   // hand the result to the output register
	} state_t;

	state_t                state_q;
	rrqs_pkg::kind_t       kind_q;
	logic [TID_W-1:0]      tid_q;
	logic [QV_W-1:0]       qv_q;
	logic [TID_W-1:0]      key_q;
	logic                  sw_q;
	logic                  pop_q;

	logic [TID_W-1:0]      running_q;
	logic [QV_W-1:0]       ticks_q;
	logic [QV_W-1:0]       default_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TASK_COUNT-1:0] given_q;

	rrqs_pkg::qctl_t       qctl;
	logic                  head_vld;
	logic [TID_W-1:0]      head_id;
	logic                  found;
	logic [CNT_W-1:0]      found_ext;
	logic [CNT_W-1:0]      cnt_rm;

	logic [EXT_W-1:0]      tid_ext;
	logic [EXT_W-1:0]      run_ext;
	logic [EXT_W-1:0]      head_ext;
	logic [ADDR_W-1:0]     tid_addr;
	logic [ADDR_W-1:0]     run_addr;
	logic [ADDR_W-1:0]     head_addr;
	logic                  tid_ok;
	logic [QV_W-1:0]       tick_dec;

	logic                  ram_we;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [QV_W-1:0]       ram_rdata;
	logic                  out_free;

	// Task numbers to table addresses; extend first so any TASK_COUNT fits.
	assign tid_ext   = {{ADDR_W{1'b0}}, tid_q};
	assign run_ext   = {{ADDR_W{1'b0}}, running_q};
	assign head_ext  = {{ADDR_W{1'b0}}, head_id};
	assign tid_addr  = tid_ext[ADDR_W-1:0];
	assign run_addr  = run_ext[ADDR_W-1:0];
	assign head_addr = head_ext[ADDR_W-1:0];
	assign tid_ok    = (int'(tid_q) < TASK_COUNT);

	// Saturating countdown of the running quantum.
	assign tick_dec = (ticks_q == '0) ? '0 : ticks_q - 1'b1;

	// Tail slot after the unlink: the old count less one if the key was found.
	assign found_ext = {{(CNT_W-1){1'b0}}, found};
	assign cnt_rm    = cnt_q - found_ext;

	always_comb begin
		qctl        = '0;
		qctl.key    = key_q;
		qctl.rm_en  = (state_q == S_RA);
		qctl.app_en = (state_q == S_RA);
		qctl.pop    = (state_q == S_POP);
	end

	rrqs_queue #(
		.TASK_COUNT (TASK_COUNT)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.app_pos  (cnt_rm[ADDR_W-1:0]),
		.head_vld (head_vld),
		.head_id  (head_id),
		.found    (found)
	);

	// Per-task quantum table; only entries flagged in given_q are ever used.
	assign ram_we    = (state_q == S_EXEC) && (kind_q == rrqs_pkg::K_SETQ) && tid_ok;
	assign ram_re    = (state_q == S_POP) ||
	                   ((state_q == S_EXEC) && (kind_q == rrqs_pkg::K_DISPATCH));
	assign ram_raddr = (state_q == S_POP) ? head_addr : IDLE_ADDR;

	rrqs_ram #(
		.WIDTH (QV_W),
		.DEPTH (TASK_COUNT)
	) u_quantum_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (tid_addr),
		.wr_data (qv_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= rrqs_pkg::K_TICK;
			tid_q         <= '0;
			qv_q          <= '0;
			key_q         <= '0;
			sw_q          <= 1'b0;
			pop_q         <= 1'b0;
			running_q     <= rrqs_pkg::RESET_RUN_ID;
			ticks_q       <= rrqs_pkg::RESET_QUANTUM;
			default_q     <= rrqs_pkg::RESET_QUANTUM;
			cnt_q         <= '0;
			given_q       <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			// Drop the result beat once taken, unless the last step below replaces it.
			if (m_axis_tvalid && m_axis_tready && (state_q != S_DONE)) begin
				m_axis_tvalid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q  <= rrqs_pkg::kind_t'(s_axis_tuser);
						tid_q   <= s_axis_tdata[TID_W-1:0];
						qv_q    <= s_axis_tdata[TID_W +: QV_W];
						sw_q    <= 1'b0;
						pop_q   <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (kind_q)
						rrqs_pkg::K_TICK: begin
							ticks_q <= tick_dec;
							if ((tick_dec == '0) && (cnt_q != '0)) begin
								// Quantum spent: requeue the runner (idle task stays out), then pop.
								sw_q  <= 1'b1;
								pop_q <= 1'b1;
								if (running_q != IDLE_TID) begin
									key_q   <= running_q;
									state_q <= S_RA;
								end else begin
									state_q <= S_POP;
								end
							end else begin
								state_q <= S_DONE;
							end
						end
						rrqs_pkg::K_READY: begin
							if (tid_ok) begin
								key_q   <= tid_q;
								state_q <= S_RA;
							end else begin
								state_q <= S_DONE;
							end
						end
						rrqs_pkg::K_DISPATCH: begin
							sw_q <= 1'b1;
							if (cnt_q != '0) begin
								state_q <= S_POP;
							end else begin
								// Empty queue: fall back to the idle task, read already issued.
								running_q <= IDLE_TID;
								state_q   <= S_LOAD;
							end
						end
						rrqs_pkg::K_SETQ: begin
							if (tid_ok) begin
								given_q[tid_addr] <= 1'b1;
							end
							state_q <= S_DONE;
						end
					endcase
				end
				S_RA: begin
					cnt_q   <= cnt_rm + 1'b1;
					state_q <= pop_q ? S_POP : S_DONE;
				end
				S_POP: begin
					running_q <= head_id;
					cnt_q     <= cnt_q - 1'b1;
					state_q   <= S_LOAD;
				end
				S_LOAD: begin
					ticks_q <= given_q[run_addr] ? ram_rdata : default_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {(cnt_q == '0), sw_q, ticks_q, running_q};
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Default, quantum reload; user writes only while idle, unchecked.
			if (cfg_wr_en) begin
				default_q <= cfg_wr_data;
				ticks_q   <= cfg_wr_data;
			end
		end
	end

	// The fill count and the head cell agree on emptiness.
	`RRQS_ASSERT_IMP(a_empty_head, 1'b1, (cnt_q == '0) == !head_vld, "queue count and head cell disagree")
	// A pop makes the old head the running task and goes on to the quantum load.
	`RRQS_ASSERT_NXT(a_pop_load, state_q == S_POP, (state_q == S_LOAD) && (running_q == $past(head_id)), "pop did not dispatch the head")
	// The last step always issues a result beat when the output register is free.
	`RRQS_ASSERT_NXT(a_beat_out, (state_q == S_DONE) && out_free, m_axis_tvalid && (state_q == S_IDLE), "result beat not issued")
	// The queue never holds more entries than there are tasks.
	`RRQS_ASSERT_IMP(a_cnt_max, 1'b1, int'(cnt_q) <= TASK_COUNT, "queue count overflow")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the round-robin quantum scheduler core.
`timescale 1ns / 1ps
module testbench;
	import rrqs_pkg::*;

	localparam int TASKS      = TASK_COUNT_DEF;
	localparam int IDLE_NUM   = IDLE_ID_DEF;
	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_LEN   = 400;
	localparam int PHASE_LEN  = 450;

	typedef struct packed {
		logic [TID_W-1:0] run;
		logic [QV_W-1:0]  quantum;
		logic             switched;
		logic             empty;
	} sched_result_t;

	// Scheduler state mirror: note_input advances it and queues the beat due back.
	class sched_scoreboard;
		logic [QV_W-1:0]  default_q;
		logic [QV_W-1:0]  ticks;
		logic [TID_W-1:0] run_id, head, tail;
		int               count;
		bit               in_q  [TASKS];
		logic [TID_W-1:0] nxt   [TASKS];
		logic [TID_W-1:0] prv   [TASKS];
		logic [QV_W-1:0]  own_q [TASKS];
		bit               given [TASKS];
		sched_result_t    due_q [$];
		int               errors;

		function new();
			default_q = RESET_QUANTUM;
			ticks     = RESET_QUANTUM;
			run_id    = RESET_RUN_ID;
			head      = '0;
			tail      = '0;
			count     = 0;
			errors    = 0;
			for (int i = 0; i < TASKS; i++) begin
				in_q[i]  = 1'b0;
				given[i] = 1'b0;
				nxt[i]   = '0;
				prv[i]   = '0;
				own_q[i] = '0;
			end
		endfunction

		function void unlink_task(logic [TID_W-1:0] t);
			logic [TID_W-1:0] p, n;
			if (!in_q[t])
				return;
			p = prv[t];
			n = nxt[t];
			if (t == head)
				head = n;
			else
				nxt[p] = n;
			if (t == tail)
				tail = p;
			else
				prv[n] = p;
			in_q[t] = 1'b0;
			if (count > 0)
				count--;
		endfunction

		function void append_task(logic [TID_W-1:0] t);
			if (count == 0) begin
				head = t;
				tail = t;
			end else begin
				nxt[tail] = t;
				prv[t]    = tail;
				tail      = t;
			end
			in_q[t] = 1'b1;
			count++;
		endfunction

		// Run the queue head, or the idle task when nothing is ready.
		function void dispatch_head();
			logic [TID_W-1:0] t;
			if (count != 0) begin
				t = head;
				unlink_task(t);
			end else begin
				t = TID_W'(IDLE_NUM);
			end
			run_id = t;
			ticks  = given[t] ? own_q[t] : default_q;
		endfunction

		function void configure(logic [QV_W-1:0] v);
			default_q = v;
			ticks     = v;
		endfunction

		function void note_input(kind_t kind, logic [TID_W-1:0] tid, logic [QV_W-1:0] qv);
			sched_result_t r;
			logic          sw;
			sw = 1'b0;
			case (kind)
				K_TICK: begin
					if (ticks != 0)
						ticks--;
					if (ticks == 0 && count != 0) begin
						if (run_id != TID_W'(IDLE_NUM)) begin
							unlink_task(run_id);
							append_task(run_id);
						end
						dispatch_head();
						sw = 1'b1;
					end
				end
				K_READY: begin
					unlink_task(tid);
					append_task(tid);
				end
				K_DISPATCH: begin
					dispatch_head();
					sw = 1'b1;
				end
				default: begin
					own_q[tid] = qv;
					given[tid] = 1'b1;
				end
			endcase
			r.run      = run_id;
			r.quantum  = ticks;
			r.switched = sw;
			r.empty    = (count == 0);
			due_q.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d);
			sched_result_t got, want;
			bit            bad;
			got.run      = d[5:0];
			got.quantum  = d[21:6];
			got.switched = d[22];
			got.empty    = d[23];
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: run=%0d q=%0d sw=%0b empty=%0b",
						got.run, got.quantum, got.switched, got.empty);
				return;
			end
			want = due_q.pop_front();
			bad  = 1'b0;
			if (got.run !== want.run)
				bad = 1'b1;
			if (got.quantum !== want.quantum)
				bad = 1'b1;
			if (got.switched !== want.switched)
				bad = 1'b1;
			if (got.empty !== want.empty)
				bad = 1'b1;
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected run=%0d q=%0d sw=%0b empty=%0b, ",
						"got run=%0d q=%0d sw=%0b empty=%0b"},
						want.run, want.quantum, want.switched, want.empty,
						got.run, got.quantum, got.switched, got.empty);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [QV_W-1:0]      cfg_wr_data   = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [KIND_W-1:0]    s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	sched_scoreboard sb;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              hold_left = 0;
	int              quiet_cycles = 0;

	round_robin_quantum_scheduler_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // task_id, quantum_value, zero pad
		.s_axis_tuser  (s_axis_tuser),   // kind
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // running_task, quantum_left, switched, queue_empty
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one beat after an optional random gap; return at its accepting edge.
	task automatic send_item(kind_t kind, logic [TID_W-1:0] tid, logic [QV_W-1:0] qv);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, qv, tid};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(kind, tid, qv);
	endtask

	// Drop valid and wait until every result is back, plus a latency margin.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_default_quantum(logic [QV_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.configure(v);
	endtask

	// Mostly ticks and make-ready on a few tasks so the queue churns and quanta expire.
	task automatic send_random_item();
		kind_t            kind;
		logic [TID_W-1:0] tid;
		logic [QV_W-1:0]  qv;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			kind = K_TICK;
		else if (pick < 75)
			kind = K_READY;
		else if (pick < 83)
			kind = K_DISPATCH;
		else
			kind = K_SETQ;
		if ($urandom_range(0, 1))
			tid = TID_W'($urandom_range(0, 7));
		else
			tid = TID_W'($urandom_range(0, TASKS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			qv = QV_W'($urandom_range(0, 8));
		else if (pick < 75)
			qv = '0;
		else if (pick < 80)
			qv = '1;
		else
			qv = QV_W'($urandom_range(0, 65535));
		send_item(kind, tid, qv);
	endtask

	initial begin
		logic [QV_W-1:0] phase_cfg [4];
		sb = new();
		phase_cfg[0] = 16'd3;
		phase_cfg[1] = 16'hFFFF;
		phase_cfg[2] = 16'd1;
		phase_cfg[3] = QV_W'($urandom_range(1, 20));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state first, then a zero default quantum.
		send_item(K_TICK, 6'd0, 16'd0);
		send_item(K_TICK, 6'd63, 16'hFFFF);
		set_default_quantum(16'd0);
		// Expired with the queue empty: quantum holds at zero.
		send_item(K_TICK, 6'd0, 16'd0);
		send_item(K_SETQ, 6'd63, 16'hFFFF);
		send_item(K_SETQ, 6'd0, 16'd0);
		send_item(K_SETQ, 6'd2, 16'd1);
		send_item(K_READY, 6'd2, 16'd0);
		send_item(K_READY, 6'd63, 16'd0);
		send_item(K_READY, 6'd0, 16'd0);   // idle task queued like any other
		send_item(K_READY, 6'd1, 16'd0);   // running task made ready
		send_item(K_DISPATCH, 6'd0, 16'd0);
		send_item(K_TICK, 6'd0, 16'd0);    // expire and requeue
		send_item(K_DISPATCH, 6'd0, 16'd0);
		send_item(K_TICK, 6'd0, 16'd0);    // idle task expires, not requeued
		send_item(K_READY, 6'd2, 16'd0);   // already queued, moves to the tail
		send_item(K_DISPATCH, 6'd0, 16'd0);
		send_item(K_DISPATCH, 6'd0, 16'd0);
		send_item(K_DISPATCH, 6'd0, 16'd0);
		send_item(K_DISPATCH, 6'd0, 16'd0); // empty queue: idle task, still switched
		send_item(K_TICK, 6'd0, 16'd0);
		send_item(K_READY, 6'd5, 16'd0);
		send_item(K_TICK, 6'd0, 16'd0);
		send_item(K_SETQ, 6'd42, 16'h8000);
		send_item(K_DISPATCH, 6'd0, 16'd0);

		for (int ph = 0; ph < 4; ph++) begin
			set_default_quantum(phase_cfg[ph]);
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (ph == 0 && i == 200)
					hold_left = HOLD_LEN;
				send_random_item();
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
